>>> hdl/qrs_onset_end_locator_assert.svh
// Assertion macros for the QRS onset and end locator.
// Included by the top level; depends on nothing else.
`ifndef QRS_ONSET_END_LOCATOR_ASSERT_SVH
`define QRS_ONSET_END_LOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QOL_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QOL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/qol_pkg.sv
// Package for the QRS onset and end locator: command codes and transaction types.
// Depends on nothing; used by the sequencer and the top level.
`timescale 1ns / 1ps

package qol_pkg;

	localparam logic [1:0] OP_LOAD_SAMPLE = 2'd0;
	localparam logic [1:0] OP_LOAD_PEAK   = 2'd1;
	localparam logic [1:0] OP_RUN         = 2'd2;
	localparam logic [1:0] OP_CLEAR       = 2'd3;

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [15:0] sample_value;
		logic [11:0]        peak_position;
	} cmd_t;

	typedef struct packed {
		logic [5:0]  beat_index;
		logic [11:0] onset_pos;
		logic [11:0] qrs_end;
		logic        polarity_inverted;
		logic        last_beat;
	} result_t;

endpackage

>>> hdl/qrs_onset_end_locator.sv
// QRS onset and end locator usage:
// A command transaction is taken on a rising edge with start high and busy low.
// cmd.opcode selects: load sample, load R-peak position, run search, clear stores.
// Loads and clear do not raise busy, so they may follow back to back; a load
// past the capacity of its store is dropped. Clear empties both stores at once.
// A run raises busy and gives one result per stored peak, in peak order. Each
// result transaction is marked by strobe, which is high for exactly one cycle;
// the receiver cannot hold it off. last_beat marks the final one of a run.
// Run steps: the polarity decision passes through POL0, POL1, POL2 and, with
// more than one stored peak, POL3; then per beat a peak read and a clamp,
// plus for each walk a priming state and a walk state that steps one sample at
// a time; the one read port of the sample store is streamed one address ahead.
// Busy falls in the cycle the last result is shown; a run with no stored peaks
// gives no results, and with no samples each beat gives a result with zero onset and end.
// Reset empties both stores and returns the sequencer to idle; store contents
// are left as they were and are never used before being rewritten.
// Depends on qol_pkg, qol_ram, qol_seq and the assertion macro header.
`timescale 1ns / 1ps
`include "qrs_onset_end_locator_assert.svh"

module qrs_onset_end_locator #(
	parameter int SAMPLE_DEPTH = 4096,
	parameter int MAX_PEAKS = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  qol_pkg::cmd_t    cmd,
	output logic             strobe,
	output qol_pkg::result_t result
);

	import qol_pkg::*;

	localparam int SI = $clog2(SAMPLE_DEPTH);
	localparam int SC = $clog2(SAMPLE_DEPTH + 1);
	localparam int PI = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
	localparam int PCW = $clog2(MAX_PEAKS + 1);

	logic                   accept;
	logic [SC-1:0]          sample_count_q;
	logic [PCW-1:0]         peak_count_q;
	logic                   s_we;
	logic                   p_we;
	logic                   s_drop;
	logic [SAMPLE_BITS-1:0] s_wdata;
	logic [SI-1:0]          s_raddr;
	logic [SAMPLE_BITS-1:0] s_rdata;
	logic [PI-1:0]          p_raddr;
	logic [11:0]            p_rdata;
	logic                   run;

	assign accept = start && !busy;
	assign run    = accept && (cmd.opcode == OP_RUN);
	assign s_we   = accept && (cmd.opcode == OP_LOAD_SAMPLE)
		&& (sample_count_q < SC'(SAMPLE_DEPTH));
	assign p_we   = accept && (cmd.opcode == OP_LOAD_PEAK)
		&& (peak_count_q < PCW'(MAX_PEAKS));
	assign s_drop = accept && (cmd.opcode == OP_LOAD_SAMPLE) && !s_we;

	// Narrow samples keep their low bits; wide ones are sign-extended.
	generate
		if (SAMPLE_BITS <= 16) begin : g_narrow
			assign s_wdata = cmd.sample_value[SAMPLE_BITS-1:0];
		end else begin : g_wide
			assign s_wdata = {{(SAMPLE_BITS - 16){cmd.sample_value[15]}}, cmd.sample_value};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= '0;
			peak_count_q   <= '0;
		end else begin
			if (accept && (cmd.opcode == OP_CLEAR)) begin
				sample_count_q <= '0;
				peak_count_q   <= '0;
			end else begin
				if (s_we) begin
					sample_count_q <= sample_count_q + SC'(1);
				end
				if (p_we) begin
					peak_count_q <= peak_count_q + PCW'(1);
				end
			end
		end
	end

	qol_ram #(
		.DEPTH(SAMPLE_DEPTH),
		.WIDTH(SAMPLE_BITS)
	) u_sample_ram (
		.clk  (clk),
		.we   (s_we),
		.waddr(sample_count_q[SI-1:0]),
		.wdata(s_wdata),
		.raddr(s_raddr),
		.rdata(s_rdata)
	);

	qol_ram #(
		.DEPTH(MAX_PEAKS),
		.WIDTH(12)
	) u_peak_ram (
		.clk  (clk),
		.we   (p_we),
		.waddr(peak_count_q[PI-1:0]),
		.wdata(cmd.peak_position),
		.raddr(p_raddr),
		.rdata(p_rdata)
	);

	qol_seq #(
		.SAMPLE_DEPTH(SAMPLE_DEPTH),
		.MAX_PEAKS   (MAX_PEAKS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.run         (run),
		.sample_count(sample_count_q),
		.peak_count  (peak_count_q),
		.s_raddr     (s_raddr),
		.s_rdata     (s_rdata),
		.p_raddr     (p_raddr),
		.p_rdata     (p_rdata),
		.busy        (busy),
		.strobe      (strobe),
		.result      (result)
	);

	`QOL_ASSERT_IMPLY(a_strobe_from_run, clk, arst_n, strobe, $past(busy), "result outside a run")
	`QOL_ASSERT_NEXT(a_last_gap, clk, arst_n, strobe && result.last_beat, !strobe, "strobe after last")
	`QOL_ASSERT_NEXT(a_full_drop, clk, arst_n, s_drop, $stable(sample_count_q), "full store grew")
	`QOL_ASSERT_NEXT(a_empty_run, clk, arst_n, run && peak_count_q == '0, !busy, "empty run went busy")

endmodule

>>> hdl/qol_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Stand-alone; holds the sample store and the peak store.
`timescale 1ns / 1ps

module qol_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/qol_seq.sv
// Run sequencer: polarity decision, then onset and end walks for each stored beat.
// Depends on qol_pkg; reads both stores through their registered read ports.
`timescale 1ns / 1ps

module qol_seq #(
	parameter int SAMPLE_DEPTH = 4096,
	parameter int MAX_PEAKS = 64,
	parameter int SAMPLE_BITS = 16,
	localparam int SI = $clog2(SAMPLE_DEPTH),
	localparam int SC = $clog2(SAMPLE_DEPTH + 1),
	localparam int PI = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1,
	localparam int PCW = $clog2(MAX_PEAKS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   run,
	input  logic [SC-1:0]          sample_count,
	input  logic [PCW-1:0]         peak_count,
	output logic [SI-1:0]          s_raddr,
	input  logic [SAMPLE_BITS-1:0] s_rdata,
	output logic [PI-1:0]          p_raddr,
	input  logic [11:0]            p_rdata,
	output logic                   busy,
	output logic                   strobe,
	output qol_pkg::result_t       result
);

	import qol_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int PW = (SC > 12) ? SC : 12;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_POL0     = 4'd1;
	localparam logic [3:0] ST_POL1     = 4'd2;
	localparam logic [3:0] ST_POL2     = 4'd3;
	localparam logic [3:0] ST_POL3     = 4'd4;
	localparam logic [3:0] ST_PEAK     = 4'd5;
	localparam logic [3:0] ST_CLAMP    = 4'd6;
	localparam logic [3:0] ST_ON_FIRST = 4'd7;
	localparam logic [3:0] ST_ON       = 4'd8;
	localparam logic [3:0] ST_EN_FIRST = 4'd9;
	localparam logic [3:0] ST_EN       = 4'd10;
	localparam logic [3:0] ST_EMPTY    = 4'd11;

	logic [3:0]    state_q;
	logic [PI-1:0] k_q;
	logic          inv_q;
	logic [SI-1:0] p_q;
	logic [SI-1:0] j_q;
	logic [SI-1:0] s_ra_q;
	logic [SI-1:0] onset_q;
	logic [SB-1:0] a_q;
	logic          dec_q;
	logic          minr_q;
	result_t       result_q;
	logic          strobe_q;

	logic [SC-1:0] last_w;
	logic [SI-1:0] last_c;
	logic [PW-1:0] pos_ext;
	logic [PW-1:0] cnt_ext;
	logic [SI-1:0] clamp_c;
	logic signed [SB-1:0] av;
	logic signed [SB-1:0] sd;
	logic          gt;
	logic          lt;
	logic          dec_n;
	logic          minr_n;
	logic          stop;
	logic [SB:0]   sum_c;
	logic          last_beat_c;
	logic          on_done;
	logic          en_done;
	logic [SI-1:0] on_val;
	logic [SI-1:0] en_val;

	function automatic logic [11:0] to12(input logic [SI-1:0] idx);
		logic [SI+11:0] wide;
		wide = (SI + 12)'(idx);
		return wide[11:0];
	endfunction

	function automatic logic [5:0] to6(input logic [PI-1:0] idx);
		logic [PI+5:0] wide;
		wide = (PI + 6)'(idx);
		return wide[5:0];
	endfunction

	assign last_w  = sample_count - SC'(1);
	assign last_c  = last_w[SI-1:0];
	assign pos_ext = PW'(p_rdata);
	assign cnt_ext = PW'(sample_count);
	assign clamp_c = (pos_ext >= cnt_ext) ? last_c : pos_ext[SI-1:0];

	// Inversion swaps the comparison rather than negating the samples.
	assign av     = $signed(a_q);
	assign sd     = $signed(s_rdata);
	assign gt     = inv_q ? (av < sd) : (av > sd);
	assign lt     = inv_q ? (av > sd) : (av < sd);
	assign dec_n  = dec_q | gt;
	assign minr_n = minr_q | (lt & dec_q);
	assign stop   = minr_n & dec_n & gt;

	assign sum_c = {a_q[SB-1], a_q} + {s_rdata[SB-1], s_rdata};
	assign last_beat_c = ((PCW'(k_q) + PCW'(1)) == peak_count);

	// A turning point found on the very last step of a walk does not count.
	assign on_done = stop || (j_q == SI'(1));
	assign on_val  = (stop && (j_q != SI'(1))) ? j_q : '0;
	assign en_done = stop || ((j_q + SI'(1)) == last_c);
	assign en_val  = (stop && ((j_q + SI'(1)) != last_c)) ? j_q : last_c;

	always_comb begin
		s_raddr = s_ra_q;
		p_raddr = k_q;
		unique case (state_q)
			ST_POL0: begin
				p_raddr = '0;
			end
			ST_POL1: begin
				s_raddr = clamp_c;
				p_raddr = PI'(1);
			end
			ST_POL2: begin
				s_raddr = clamp_c;
			end
			ST_CLAMP: begin
				s_raddr = clamp_c;
			end
			ST_ON_FIRST: begin
				s_raddr = p_q - SI'(1);
			end
			ST_ON: begin
				if (on_done) begin
					s_raddr = p_q;
				end else begin
					s_raddr = (s_ra_q == '0) ? '0 : s_ra_q - SI'(1);
				end
			end
			ST_EN_FIRST: begin
				s_raddr = p_q + SI'(1);
			end
			ST_EN: begin
				s_raddr = (s_ra_q == last_c) ? last_c : s_ra_q + SI'(1);
			end
			default: begin
				s_raddr = s_ra_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		s_ra_q <= s_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			inv_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					k_q   <= '0;
					inv_q <= 1'b0;
					if (run && (peak_count != '0)) begin
						state_q <= (sample_count == '0) ? ST_EMPTY : ST_POL0;
					end
				end
				ST_POL0: begin
					state_q <= ST_POL1;
				end
				ST_POL1: begin
					state_q <= ST_POL2;
				end
				ST_POL2: begin
					if (peak_count > PCW'(1)) begin
						state_q <= ST_POL3;
					end else begin
						inv_q   <= s_rdata[SB-1];
						state_q <= ST_PEAK;
					end
				end
				ST_POL3: begin
					inv_q   <= sum_c[SB];
					state_q <= ST_PEAK;
				end
				ST_PEAK: begin
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					if (clamp_c != '0) begin
						state_q <= ST_ON_FIRST;
					end else if (clamp_c != last_c) begin
						state_q <= ST_EN_FIRST;
					end else begin
						strobe_q <= 1'b1;
						state_q  <= last_beat_c ? ST_IDLE : ST_PEAK;
						k_q      <= k_q + PI'(1);
					end
				end
				ST_ON_FIRST: begin
					state_q <= ST_ON;
				end
				ST_ON: begin
					if (on_done) begin
						if (p_q != last_c) begin
							state_q <= ST_EN_FIRST;
						end else begin
							strobe_q <= 1'b1;
							state_q  <= last_beat_c ? ST_IDLE : ST_PEAK;
							k_q      <= k_q + PI'(1);
						end
					end
				end
				ST_EN_FIRST: begin
					state_q <= ST_EN;
				end
				ST_EN: begin
					if (en_done) begin
						strobe_q <= 1'b1;
						state_q  <= last_beat_c ? ST_IDLE : ST_PEAK;
						k_q      <= k_q + PI'(1);
					end
				end
				ST_EMPTY: begin
					strobe_q <= 1'b1;
					state_q  <= last_beat_c ? ST_IDLE : ST_EMPTY;
					k_q      <= k_q + PI'(1);
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk registers and the result word carry no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_POL2: begin
				a_q <= s_rdata;
			end
			ST_CLAMP: begin
				p_q     <= clamp_c;
				onset_q <= '0;
				result_q.beat_index        <= to6(k_q);
				result_q.onset_pos         <= '0;
				result_q.qrs_end           <= to12(last_c);
				result_q.polarity_inverted <= inv_q;
				result_q.last_beat         <= last_beat_c;
			end
			ST_ON_FIRST, ST_EN_FIRST: begin
				a_q    <= s_rdata;
				j_q    <= p_q;
				dec_q  <= 1'b0;
				minr_q <= 1'b0;
			end
			ST_ON: begin
				a_q    <= s_rdata;
				j_q    <= j_q - SI'(1);
				dec_q  <= dec_n;
				minr_q <= minr_n;
				if (on_done) begin
					onset_q <= on_val;
					result_q.beat_index        <= to6(k_q);
					result_q.onset_pos         <= to12(on_val);
					result_q.qrs_end           <= to12(last_c);
					result_q.polarity_inverted <= inv_q;
					result_q.last_beat         <= last_beat_c;
				end
			end
			ST_EN: begin
				a_q    <= s_rdata;
				j_q    <= j_q + SI'(1);
				dec_q  <= dec_n;
				minr_q <= minr_n;
				if (en_done) begin
					result_q.beat_index        <= to6(k_q);
					result_q.onset_pos         <= to12(onset_q);
					result_q.qrs_end           <= to12(en_val);
					result_q.polarity_inverted <= inv_q;
					result_q.last_beat         <= last_beat_c;
				end
			end
			ST_EMPTY: begin
				result_q.beat_index        <= to6(k_q);
				result_q.onset_pos         <= '0;
				result_q.qrs_end           <= '0;
				result_q.polarity_inverted <= 1'b0;
				result_q.last_beat         <= last_beat_c;
			end
			default: begin
				a_q <= a_q;
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

endmodule
